// File: rtl/yuv422_to_rgb_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter assertion macros
// Shared assertion wrappers for the converter modules.
// ----------------------------------------------------------------------------
`ifndef YUV422_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define YUV422_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define Y2R_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define Y2R_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter package
// Widths, coefficients, codes and shared types of the converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

   localparam int PIX_W      = 8;
   localparam int LUMA_W     = 9;
   localparam int CHROMA_W   = 8;
   localparam int PROD_W     = 20;
   localparam int SUM_W      = 21;
   localparam int DIV_W      = 18;
   localparam int RECIP_W    = 19;
   localparam int RECIP_SHIFT = 28;
   localparam int CHAN_NUM   = 3;
   localparam int LANE_NUM   = 2;
   localparam int REQ_DATA_W = 4 * PIX_W;
   localparam int RSP_DATA_W = LANE_NUM * CHAN_NUM * PIX_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [PROD_W-1:0] COEF_Y    = 20'sd1164;
   localparam logic signed [PROD_W-1:0] COEF_R_CR = 20'sd1596;
   localparam logic signed [PROD_W-1:0] COEF_G_CB = 20'sd392;
   localparam logic signed [PROD_W-1:0] COEF_G_CR = 20'sd813;
   localparam logic signed [PROD_W-1:0] COEF_B_CB = 20'sd2017;

   localparam logic [LUMA_W-1:0]       LUMA_OFFSET  = 9'd16;
   localparam logic signed [SUM_W-1:0] DARK_LIMIT   = 21'sd1000;
   localparam logic signed [SUM_W-1:0] BRIGHT_LIMIT = 21'sd256000;
   localparam logic [RECIP_W-1:0]      RECIP_1000   = 19'd268436;
   localparam logic [PIX_W-1:0]        CHAN_MAX     = 8'd255;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_ORDER = 2'd0;
   localparam logic ORDER_YUYV = 1'b0;
   localparam logic ORDER_UYVY = 1'b1;

   typedef struct packed {
      logic load_mul;
      logic load_sum;
      logic load_div;
   } y2r_stage_ctl_type;

   typedef struct packed {
      logic             dark;
      logic             bright;
      logic [PIX_W-1:0] quot;
   } y2r_chan_type;

endpackage

// File: rtl/y2r_lane.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter pixel lane
// Converts one luma sample and the shared chroma pair into three channel
// results: products, sums with range flags, then division by 1000.
// ----------------------------------------------------------------------------
module y2r_lane
   import y2r_pkg::*;
(
   input  logic                       clock,
   input  y2r_stage_ctl_type          ctl,
   input  logic signed [LUMA_W-1:0]   luma,
   input  logic signed [CHROMA_W-1:0] cb,
   input  logic signed [CHROMA_W-1:0] cr,
   output y2r_chan_type [CHAN_NUM-1:0] chan
);

   logic signed [PROD_W-1:0] luma_ext, cb_ext, cr_ext;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0] prod_rcr_ff, prod_rcr_in;
   logic signed [PROD_W-1:0] prod_gcb_ff, prod_gcb_in;
   logic signed [PROD_W-1:0] prod_gcr_ff, prod_gcr_in;
   logic signed [PROD_W-1:0] prod_bcb_ff, prod_bcb_in;

   logic signed [SUM_W-1:0] sum [CHAN_NUM];
   logic [DIV_W-1:0]        val_ff   [CHAN_NUM];
   logic [DIV_W-1:0]        val_in   [CHAN_NUM];
   logic                    dark_ff  [CHAN_NUM];
   logic                    dark_in  [CHAN_NUM];
   logic                    bright_ff [CHAN_NUM];
   logic                    bright_in [CHAN_NUM];

   logic [DIV_W+RECIP_W-1:0] recip_prod [CHAN_NUM];
   y2r_chan_type [CHAN_NUM-1:0] chan_ff, chan_in;

   assign luma_ext = PROD_W'(luma);
   assign cb_ext   = PROD_W'(cb);
   assign cr_ext   = PROD_W'(cr);

   always_comb begin
      prod_y_in   = luma_ext * COEF_Y;
      prod_rcr_in = cr_ext * COEF_R_CR;
      prod_gcb_in = cb_ext * COEF_G_CB;
      prod_gcr_in = cr_ext * COEF_G_CR;
      prod_bcb_in = cb_ext * COEF_B_CB;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod_y_ff   <= prod_y_in;
         prod_rcr_ff <= prod_rcr_in;
         prod_gcb_ff <= prod_gcb_in;
         prod_gcr_ff <= prod_gcr_in;
         prod_bcb_ff <= prod_bcb_in;
      end
   end

   always_comb begin
      sum[CH_RED]   = SUM_W'(prod_y_ff) + SUM_W'(prod_rcr_ff);
      sum[CH_GREEN] = SUM_W'(prod_y_ff) - SUM_W'(prod_gcb_ff) - SUM_W'(prod_gcr_ff);
      sum[CH_BLUE]  = SUM_W'(prod_y_ff) + SUM_W'(prod_bcb_ff);
      for (int c = 0; c < CHAN_NUM; c++) begin
         dark_in[c]   = sum[c] < DARK_LIMIT;
         bright_in[c] = sum[c] >= BRIGHT_LIMIT;
         val_in[c]    = sum[c][DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_sum) begin
         for (int c = 0; c < CHAN_NUM; c++) begin
            val_ff[c]    <= val_in[c];
            dark_ff[c]   <= dark_in[c];
            bright_ff[c] <= bright_in[c];
         end
      end
   end

   // Division by 1000 is a multiplication by a rounded-up reciprocal; it is
   // exact for every value below the bright limit.
   always_comb begin
      for (int c = 0; c < CHAN_NUM; c++) begin
         recip_prod[c]     = (DIV_W+RECIP_W)'(val_ff[c]) * (DIV_W+RECIP_W)'(RECIP_1000);
         chan_in[c].dark   = dark_ff[c];
         chan_in[c].bright = bright_ff[c];
         chan_in[c].quot   = recip_prod[c][RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_div) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

// File: rtl/y2r_merge.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter merge stage
// Resolves the range flags of both lanes and packs the output word.
// ----------------------------------------------------------------------------
module y2r_merge
   import y2r_pkg::*;
(
   input  logic                        clock,
   input  logic                        load,
   input  y2r_chan_type [CHAN_NUM-1:0] lane_chan [LANE_NUM],
   output logic [RSP_DATA_W-1:0]       word
);

   logic [RSP_DATA_W-1:0] word_ff, word_in;

   always_comb begin
      word_in = '0;
      for (int l = 0; l < LANE_NUM; l++) begin
         for (int c = 0; c < CHAN_NUM; c++) begin
            priority if (lane_chan[l][c].dark) begin
               word_in[(l*CHAN_NUM+c)*PIX_W +: PIX_W] = '0;
            end else if (lane_chan[l][c].bright) begin
               word_in[(l*CHAN_NUM+c)*PIX_W +: PIX_W] = CHAN_MAX;
            end else begin
               word_in[(l*CHAN_NUM+c)*PIX_W +: PIX_W] = lane_chan[l][c].quot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

// File: rtl/yuv422_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter
// Five stages: input register, lane product, sum and division, and merge.
// Throughput: one macropixel per cycle unless rsp_tready stalls the flow.
// Every stage holds its word under backpressure; empty stages still fill.
// Reset clears all stage valid bits and sets pixel_order to YUYV.
// ----------------------------------------------------------------------------
`include "yuv422_to_rgb_converter_unit_defines.svh"

module yuv422_to_rgb_converter_unit
   import y2r_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Fields from bit 0: macropixel[31:0].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: red_first, green_first, blue_first, red_second,
   // green_second, blue_second, eight bits each.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic pixel_order_ff, pixel_order_in;
   logic csr_write;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in, out_v_ff, out_v_in;
   logic rdy1, rdy2, rdy3, rdy4, out_rdy;

   logic [PIX_W-1:0] byte_in [4];
   logic [PIX_W-1:0] y0_byte, y1_byte, cb_byte, cr_byte;
   logic signed [LUMA_W-1:0]   luma_ff [LANE_NUM];
   logic signed [LUMA_W-1:0]   luma_in [LANE_NUM];
   logic signed [CHROMA_W-1:0] cb_ff, cb_in, cr_ff, cr_in;

   y2r_stage_ctl_type           ctl;
   y2r_chan_type [CHAN_NUM-1:0] lane_chan [LANE_NUM];

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pixel_order_in = pixel_order_ff;
      if (csr_write && (csr_paddr == CSR_PIXEL_ORDER)) begin
         pixel_order_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr == CSR_PIXEL_ORDER) begin
         csr_prdata = CSR_DATA_W'(pixel_order_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_order_ff <= ORDER_YUYV;
      end else begin
         pixel_order_ff <= pixel_order_in;
      end
   end

   // Stage ready chain.
   assign out_rdy    = !out_v_ff || rsp_tready;
   assign rdy4       = !v4_ff || out_rdy;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign ctl.load_mul = rdy2;
   assign ctl.load_sum = rdy3;
   assign ctl.load_div = rdy4;

   always_comb begin
      v1_in    = rdy1    ? req_tvalid : v1_ff;
      v2_in    = rdy2    ? v1_ff      : v2_ff;
      v3_in    = rdy3    ? v2_ff      : v3_ff;
      v4_in    = rdy4    ? v3_ff      : v4_ff;
      out_v_in = out_rdy ? v4_ff      : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         out_v_ff <= out_v_in;
      end
   end

   // Unpacking and offset removal.
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         byte_in[b] = req_tdata[b*PIX_W +: PIX_W];
      end
      unique case (pixel_order_ff)
         ORDER_UYVY: begin
            cb_byte = byte_in[0];
            y0_byte = byte_in[1];
            cr_byte = byte_in[2];
            y1_byte = byte_in[3];
         end
         default: begin
            y0_byte = byte_in[0];
            cb_byte = byte_in[1];
            y1_byte = byte_in[2];
            cr_byte = byte_in[3];
         end
      endcase
      luma_in[0] = $signed(LUMA_W'(y0_byte) - LUMA_OFFSET);
      luma_in[1] = $signed(LUMA_W'(y1_byte) - LUMA_OFFSET);
      cb_in      = $signed({~cb_byte[PIX_W-1], cb_byte[PIX_W-2:0]});
      cr_in      = $signed({~cr_byte[PIX_W-1], cr_byte[PIX_W-2:0]});
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         luma_ff <= luma_in;
         cb_ff   <= cb_in;
         cr_ff   <= cr_in;
      end
   end

   for (genvar l = 0; l < LANE_NUM; l++) begin : g_lane
      y2r_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .luma  (luma_ff[l]),
         .cb    (cb_ff),
         .cr    (cr_ff),
         .chan  (lane_chan[l])
      );
   end

   y2r_merge u_merge (
      .clock     (clock),
      .load      (out_rdy),
      .lane_chan (lane_chan),
      .word      (rsp_tdata)
   );

   assign rsp_tvalid = out_v_ff;

   `Y2R_ASSERT(a_accept_fills, clock, reset, req_tvalid && req_tready |=> v1_ff, "accepted word did not enter the pipeline")
   `Y2R_ASSERT(a_stall_full, clock, reset, !req_tready |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_tvalid, "input stalled with an empty stage")
   `Y2R_ASSERT(a_hold_stage4, clock, reset, v4_ff && !rdy4 |=> v4_ff, "stalled word lost in the last lane stage")
   `Y2R_ASSERT(a_csr_write, clock, reset, csr_write && (csr_paddr == CSR_PIXEL_ORDER) |=> pixel_order_ff == $past(csr_pwdata[0]), "pixel order write not taken")
   `Y2R_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && !v1_ff, "pipeline not empty after reset")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter testbench
// Streams packed macropixels through the converter, under random source gaps
// and sink stalls or in steady flow, in both byte orders. Each result word is
// compared channel by channel against an integer BT.601 predictor. The order
// register is written and read back only while no word is in flight.
// ----------------------------------------------------------------------------
module testbench;
   import y2r_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 250;
   localparam int MAX_PRINTS    = 40;

   typedef struct packed {
      logic [PIX_W-1:0] blue_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] red_second;
      logic [PIX_W-1:0] blue_first;
      logic [PIX_W-1:0] green_first;
      logic [PIX_W-1:0] red_first;
   } rgb_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  order_setting = ORDER_YUYV;
   logic                  steady_flow = 1'b0;
   logic [REQ_DATA_W-1:0] pending_words[$];
   rgb_pair_type          expected_rgb[$];
   int                    words_queued = 0;
   int                    words_accepted = 0;
   int                    words_checked = 0;
   int                    gap_left = 0;
   int                    stall_left = 0;
   int                    cycle_count = 0;
   int                    error_count = 0;
   int                    order_writes = 0;
   string                 field_names[6] = '{"red_first", "green_first", "blue_first",
                                             "red_second", "green_second", "blue_second"};

   yuv422_to_rgb_converter_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic logic [PIX_W-1:0] clamp_channel(input int sum);
      int q;
      q = (sum < 999) ? 999 : sum;
      q = q / 1000;
      if (q > 255) begin
         q = 255;
      end
      return q[PIX_W-1:0];
   endfunction

   function automatic rgb_pair_type convert_macropixel(input logic [REQ_DATA_W-1:0] word,
                                                       input logic order);
      int y0, y1, cb, cr;
      rgb_pair_type px;
      if (order == ORDER_UYVY) begin
         cb = int'(word[7:0]);
         y0 = int'(word[15:8]);
         cr = int'(word[23:16]);
         y1 = int'(word[31:24]);
      end else begin
         y0 = int'(word[7:0]);
         cb = int'(word[15:8]);
         y1 = int'(word[23:16]);
         cr = int'(word[31:24]);
      end
      y0 = 1164 * (y0 - 16);
      y1 = 1164 * (y1 - 16);
      cb = cb - 128;
      cr = cr - 128;
      px.red_first    = clamp_channel(y0 + 1596 * cr);
      px.green_first  = clamp_channel(y0 - 392 * cb - 813 * cr);
      px.blue_first   = clamp_channel(y0 + 2017 * cb);
      px.red_second   = clamp_channel(y1 + 1596 * cr);
      px.green_second = clamp_channel(y1 - 392 * cb - 813 * cr);
      px.blue_second  = clamp_channel(y1 + 2017 * cb);
      return px;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_bytes(input logic [7:0] y0, input logic [7:0] cb,
                                                        input logic [7:0] y1, input logic [7:0] cr,
                                                        input logic order);
      if (order == ORDER_UYVY) begin
         return {y1, cr, y0, cb};
      end
      return {cr, y1, cb, y0};
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd16;
         3: return 8'd235;
         4: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTS) begin
         $display("mismatch at word %0d: %s got %0d expected %0d", words_checked, what, got, want);
      end
      error_count++;
   endtask

   task automatic queue_word(input logic [REQ_DATA_W-1:0] word);
      pending_words.push_back(word);
      words_queued++;
   endtask

   task automatic wait_idle();
      while (words_accepted != words_queued || expected_rgb.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_read(output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_PIXEL_ORDER;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_pixel_order(input logic order);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] readback;
      data = (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | CSR_DATA_W'(order);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_PIXEL_ORDER;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      order_setting = order;
      order_writes++;
      @(posedge clock);
      csr_read(readback);
      if (readback !== CSR_DATA_W'(order_setting)) begin
         report_mismatch("pixel_order readback", int'(readback), int'(order_setting));
      end
   endtask

   task automatic queue_directed(input logic order);
      logic [7:0] chroma[3];
      chroma = '{8'd0, 8'd128, 8'd255};
      queue_word('0);
      queue_word('1);
      queue_word(pack_bytes(8'd16, 8'd128, 8'd235, 8'd128, order));
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            queue_word(pack_bytes(8'd0, chroma[i], 8'd255, chroma[j], order));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rgb.push_back(convert_macropixel(req_tdata, order_setting));
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               req_tvalid <= 1'b0;
               gap_left   <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               req_tdata  <= pending_words.pop_front();
               req_tvalid <= 1'b1;
               gap_left   <= steady_flow ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rgb_pair_type got;
      rgb_pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_pair_type'(rsp_tdata);
            if (expected_rgb.size() == 0) begin
               report_mismatch("unexpected word", int'(got[31:0]), 0);
            end else begin
               want = expected_rgb.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (got[i*PIX_W +: PIX_W] !== want[i*PIX_W +: PIX_W]) begin
                     report_mismatch(field_names[i], int'(got[i*PIX_W +: PIX_W]),
                                     int'(want[i*PIX_W +: PIX_W]));
                  end
               end
            end
            words_checked++;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= steady_flow ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words outstanding", cycle_count,
                  expected_rgb.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] readback;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read(readback);
      if (readback !== CSR_DATA_W'(ORDER_YUYV)) begin
         report_mismatch("pixel_order after reset", int'(readback), int'(ORDER_YUYV));
      end

      queue_directed(ORDER_YUYV);
      wait_idle();
      set_pixel_order(ORDER_UYVY);
      queue_directed(ORDER_UYVY);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_pixel_order((p % 2 == 0) ? ORDER_YUYV : ORDER_UYVY);
         steady_flow = (p % 4 == 3);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
            end else begin
               queue_word(REQ_DATA_W'($urandom));
            end
         end
         wait_idle();
      end

      $display("Converted %0d macropixels over %0d order writes in both byte orders,",
               words_checked, order_writes);
      $display("with source gaps and sink stalls; %0d mismatches.", error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
